[rtl/usc_pkg.sv]
`default_nettype none
package usc_pkg;

	localparam logic [31:0] MAX_SECONDS   = 32'd4102444799;
	localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
	localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
	localparam logic [6:0]  SEC_PER_MIN   = 7'd60;
	localparam logic [8:0]  DAYS_YEAR     = 9'd365;
	localparam logic [10:0] DAYS_CYCLE    = 11'd1461;
	localparam logic [9:0]  EARLY_DAYS    = 10'd730;
	localparam logic [10:0] LEAP_HEAD     = 11'd60;
	localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
	localparam logic [11:0] CYCLE_YEAR0   = 12'd1972;
	localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;

	// Reciprocals for the constant divisions; each estimate is low by at most one.
	localparam logic [30:0] DAY_RECIP = 31'((64'd1 << 40) / 64'd675);
	localparam logic [15:0] CYC_RECIP = 16'((32'd1 << 26) / 32'd1461);
	localparam logic [12:0] HR_RECIP  = 13'((32'd1 << 20) / 32'd225);
	localparam logic [10:0] MIN_RECIP = 11'((32'd1 << 14) / 32'd15);

	// Cycles from a start transfer to the done strobe's transfer.
	localparam int LATENCY = 7;

	localparam logic [8:0] MONTH_START [0:11] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

endpackage
`default_nettype wire

[rtl/unix_seconds_to_calendar.sv]
// Each start transfer yields exactly one done strobe from the output register.
// Throughput: one timestamp per cycle; busy is never raised, so start may be
// held high every cycle. The depth is set by the divide-by-86400 reciprocal
// multiply and the year, month and minute splits that follow it.
// Reset: arst_n clears all valid flags asynchronously; no done appears until
// an item is transferred after reset. The receiver cannot stall the output.
`default_nettype none
module unix_seconds_to_calendar
	import usc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] seconds_since_epoch,
	output logic        done,
	output logic [11:0] cal_year,
	output logic [3:0]  cal_month,
	output logic [4:0]  day_of_month,
	output logic [4:0]  hour_of_day,
	output logic [5:0]  minute_of_hour,
	output logic [5:0]  second_of_minute,
	output logic [2:0]  weekday_num
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, done_q;

	// stage 1: saturated input
	logic [31:0] t_s1;
	// stage 2: day estimate
	logic [31:0] t_s2;
	logic [15:0] est_s2;
	// stage 3: days and second of day
	logic [15:0] days_s3;
	logic [16:0] sod_s3;
	// stage 4: cycle and hour estimates
	logic [15:0] days_s4, d72_s4;
	logic [16:0] sod_s4;
	logic [5:0]  cyc_est_s4;
	logic [4:0]  hr_est_s4;
	logic        early_s4;
	// stage 5
	logic        early_s5;
	logic [9:0]  days_s5;
	logic [5:0]  cyc_s5;
	logic [10:0] dq_s5;
	logic [4:0]  hour_s5;
	logic [11:0] soh_s5;
	logic [2:0]  wd_s5;
	// stage 6
	logic [11:0] year_s6;
	logic [8:0]  doy_s6;
	logic        leap_s6;
	logic [5:0]  min_est_s6;
	logic [11:0] soh_s6;
	logic [4:0]  hour_s6;
	logic [2:0]  wd_s6;
	// output registers
	logic [11:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;
	logic [2:0]  wd_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			done_q <= v_s6;
		end
	end

	// ---------------- stage 1
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			t_s1 <= (seconds_since_epoch > MAX_SECONDS) ? MAX_SECONDS : seconds_since_epoch;
		end
	end

	// ---------------- stage 2: days ~= (t >> 7) / 675
	logic [55:0] prod_day;
	assign prod_day = 56'(t_s1[31:7]) * 56'(DAY_RECIP);

	always_ff @(posedge clk) begin
		t_s2   <= t_s1;
		est_s2 <= prod_day[55:40];
	end

	// ---------------- stage 3: correct the day estimate
	logic [32:0] day_base;
	logic [32:0] rem_day;
	logic        fix_day;
	assign day_base = 33'(est_s2) * 33'(SEC_PER_DAY);
	assign rem_day  = 33'(t_s2) - day_base;
	assign fix_day  = rem_day[17:0] >= 18'(SEC_PER_DAY);

	always_ff @(posedge clk) begin
		days_s3 <= est_s2 + 16'(fix_day);
		sod_s3  <= fix_day ? 17'(rem_day[17:0] - 18'(SEC_PER_DAY)) : rem_day[16:0];
	end

	// ---------------- stage 4: four-year cycle and hour estimates
	logic [15:0] d72;
	logic [31:0] prod_cyc;
	logic [24:0] prod_hr;
	assign d72      = days_s3 - 16'(EARLY_DAYS);
	assign prod_cyc = 32'(d72) * 32'(CYC_RECIP);
	assign prod_hr  = 25'(sod_s3[16:4]) * 25'(HR_RECIP);

	always_ff @(posedge clk) begin
		days_s4    <= days_s3;
		sod_s4     <= sod_s3;
		d72_s4     <= d72;
		cyc_est_s4 <= prod_cyc[31:26];
		hr_est_s4  <= prod_hr[24:20];
		early_s4   <= days_s3 < 16'(EARLY_DAYS);
	end

	// ---------------- stage 5: correct cycle and hour, weekday
	logic [15:0] dq_r;
	logic        fix_cyc;
	logic [16:0] rh;
	logic        fix_hr;
	logic [17:0] dw;
	logic [5:0]  oct_sum;
	logic [3:0]  oct_fold;
	logic [2:0]  wd;

	assign dq_r    = d72_s4 - 16'(cyc_est_s4) * 16'(DAYS_CYCLE);
	assign fix_cyc = dq_r >= 16'(DAYS_CYCLE);
	assign rh      = sod_s4 - 17'(hr_est_s4) * 17'(SEC_PER_HOUR);
	assign fix_hr  = rh >= 17'(SEC_PER_HOUR);

	// 8 is 1 mod 7: sum the octal digits, fold once, subtract once
	assign dw       = 18'(days_s4) + 18'(EPOCH_WEEKDAY);
	assign oct_sum  = 6'(dw[2:0]) + 6'(dw[5:3]) + 6'(dw[8:6]) + 6'(dw[11:9])
		+ 6'(dw[14:12]) + 6'(dw[17:15]);
	assign oct_fold = 4'(oct_sum[5:3]) + 4'(oct_sum[2:0]);
	assign wd       = (oct_fold >= 4'd7) ? 3'(oct_fold - 4'd7) : oct_fold[2:0];

	always_ff @(posedge clk) begin
		early_s5 <= early_s4;
		days_s5  <= days_s4[9:0];
		cyc_s5   <= cyc_est_s4 + 6'(fix_cyc);
		dq_s5    <= fix_cyc ? 11'(dq_r - 16'(DAYS_CYCLE)) : dq_r[10:0];
		hour_s5  <= hr_est_s4 + 5'(fix_hr);
		soh_s5   <= fix_hr ? 12'(rh - 17'(SEC_PER_HOUR)) : rh[11:0];
		wd_s5    <= wd;
	end

	// ---------------- stage 6: year and day of year, minute estimate
	logic [10:0] dq1;
	logic [1:0]  yoff;
	logic [10:0] yoff_days;
	logic        early_hi;
	logic [11:0] year_n;
	logic [8:0]  doy_n;
	logic        leap_n;
	logic [19:0] prod_min;

	assign dq1 = dq_s5 - 11'd1;
	assign early_hi = days_s5 >= 10'(DAYS_YEAR);
	assign prod_min = 20'(soh_s5[11:2]) * 20'(MIN_RECIP);

	always_comb begin
		if (dq1 >= 11'(3 * DAYS_YEAR)) begin
			yoff = 2'd3;
		end else if (dq1 >= 11'(2 * DAYS_YEAR)) begin
			yoff = 2'd2;
		end else if (dq1 >= 11'(DAYS_YEAR)) begin
			yoff = 2'd1;
		end else begin
			yoff = 2'd0;
		end
		yoff_days = 11'(yoff) * 11'(DAYS_YEAR);

		if (early_s5) begin
			leap_n = 1'b0;
			year_n = EPOCH_YEAR + 12'(early_hi);
			doy_n  = early_hi ? 9'(days_s5 - 10'(DAYS_YEAR)) : days_s5[8:0];
		end else if (dq_s5 < LEAP_HEAD) begin
			leap_n = 1'b1;
			year_n = CYCLE_YEAR0 + 12'({cyc_s5, 2'b00});
			doy_n  = dq_s5[8:0];
		end else begin
			leap_n = 1'b0;
			year_n = CYCLE_YEAR0 + 12'({cyc_s5, 2'b00}) + 12'(yoff);
			doy_n  = 9'(dq1 - yoff_days);
		end
	end

	always_ff @(posedge clk) begin
		year_s6    <= year_n;
		doy_s6     <= doy_n;
		leap_s6    <= leap_n;
		min_est_s6 <= prod_min[19:14];
		soh_s6     <= soh_s5;
		hour_s6    <= hour_s5;
		wd_s6      <= wd_s5;
	end

	// ---------------- stage 7: month, day, minute, second
	logic [3:0]  month_n;
	logic [8:0]  mbase;
	logic [4:0]  mday_n;
	logic [11:0] rm;
	logic        fix_min;

	always_comb begin
		month_n = 4'd1;
		mbase   = MONTH_START[0];
		for (int i = 1; i < 12; i++) begin
			if (doy_s6 >= MONTH_START[i]) begin
				month_n = 4'(i + 1);
				mbase   = MONTH_START[i];
			end
		end
		mday_n = 5'(doy_s6 - mbase + 9'd1);
		// leap-year head: January, then a 29-day February
		if (leap_s6) begin
			if (doy_s6 < MONTH_START[1]) begin
				month_n = 4'd1;
				mday_n  = 5'(doy_s6 + 9'd1);
			end else begin
				month_n = 4'd2;
				mday_n  = 5'(doy_s6 - MONTH_START[1] + 9'd1);
			end
		end
	end

	assign rm      = soh_s6 - 12'(min_est_s6) * 12'(SEC_PER_MIN);
	assign fix_min = rm >= 12'(SEC_PER_MIN);

	always_ff @(posedge clk) begin
		year_q   <= year_s6;
		month_q  <= month_n;
		day_q    <= mday_n;
		hour_q   <= hour_s6;
		minute_q <= min_est_s6 + 6'(fix_min);
		second_q <= fix_min ? 6'(rm - 12'(SEC_PER_MIN)) : rm[5:0];
		wd_q     <= wd_s6;
	end

	assign done             = done_q;
	assign cal_year         = year_q;
	assign cal_month        = month_q;
	assign day_of_month     = day_q;
	assign hour_of_day      = hour_q;
	assign minute_of_hour   = minute_q;
	assign second_of_minute = second_q;
	assign weekday_num      = wd_q;

endmodule
`default_nettype wire

[rtl/usc_checker.sv]
`default_nettype none
module usc_checker
	import usc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [11:0] cal_year,
	input logic [3:0]  cal_month,
	input logic [4:0]  day_of_month,
	input logic [4:0]  hour_of_day,
	input logic [5:0]  minute_of_hour,
	input logic [5:0]  second_of_minute,
	input logic [2:0]  weekday_num
);

	// each transfer yields exactly one strobe, and done never rises without a transfer
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		(arst_n && $past(arst_n, 1) && $past(arst_n, 2) && $past(arst_n, 3)
			&& $past(arst_n, 4) && $past(arst_n, 5) && $past(arst_n, 6)
			&& $past(arst_n, LATENCY))
		|-> (done == $past(start && !busy, LATENCY)))
		else $error("done does not match start transfer history");

	a_fields_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cal_year >= EPOCH_YEAR && cal_year <= 12'd2099
			&& cal_month >= 4'd1 && cal_month <= 4'd12
			&& day_of_month >= 5'd1 && hour_of_day <= 5'd23
			&& minute_of_hour <= 6'd59 && second_of_minute <= 6'd59
			&& weekday_num <= 3'd6))
		else $error("result field out of range");

	a_short_months: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (cal_month == 4'd4 || cal_month == 4'd6 || cal_month == 4'd9
			|| cal_month == 4'd11)) |-> day_of_month <= 5'd30)
		else $error("day past end of 30-day month");

	a_february: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cal_month == 4'd2) |->
			(day_of_month <= 5'd28 || (day_of_month == 5'd29 && cal_year[1:0] == 2'd0)))
		else $error("bad February day");

endmodule

bind unix_seconds_to_calendar usc_checker u_usc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.cal_year         (cal_year),
	.cal_month        (cal_month),
	.day_of_month     (day_of_month),
	.hour_of_day      (hour_of_day),
	.minute_of_hour   (minute_of_hour),
	.second_of_minute (second_of_minute),
	.weekday_num      (weekday_num)
);
`default_nettype wire
